[rtl/mwd_pkg.sv]
package mwd_pkg;

    // Width of one dividend or quotient word.
    localparam int WORD_W = 64;

    // Bit counter inside one word and its terminal value.
    localparam int BIT_CNT_W = 6;
    localparam logic [BIT_CNT_W-1:0] BIT_LAST = BIT_CNT_W'(WORD_W - 1);

    // Sequencer states, one-hot.
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_FETCH = 5'b00010,
        S_LATCH = 5'b00100,
        S_SHIFT = 5'b01000,
        S_READ  = 5'b10000
    } state_t;

    // Controls from the sequencer to the shift-subtract unit.
    typedef struct packed {
        logic clear_rem;
        logic load_word;
        logic step;
    } unit_ctrl_t;

endpackage

[rtl/mwd_ram.sv]
module mwd_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 4,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/mwd_bit_unit.sv]
module mwd_bit_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  mwd_pkg::unit_ctrl_t       ctrl,
    input  logic [mwd_pkg::WORD_W-1:0] load_data,
    input  logic [mwd_pkg::WORD_W-1:0] divisor,
    output logic [mwd_pkg::WORD_W-1:0] quot_next
);

    logic [mwd_pkg::WORD_W-1:0] rem_reg;
    logic [mwd_pkg::WORD_W-1:0] rem_next;
    logic [mwd_pkg::WORD_W-1:0] dvd_sh_reg;
    logic [mwd_pkg::WORD_W-1:0] quot_reg;
    logic [mwd_pkg::WORD_W:0]   shifted;
    logic [mwd_pkg::WORD_W:0]   diff;
    logic                       ge;

    // One restoring step: shift in the next dividend bit and try the subtract.
    always_comb
    begin
        shifted   = {rem_reg, dvd_sh_reg[mwd_pkg::WORD_W-1]};
        diff      = shifted - {1'b0, divisor};
        ge        = (shifted >= {1'b0, divisor});
        rem_next  = ge ? diff[mwd_pkg::WORD_W-1:0] : shifted[mwd_pkg::WORD_W-1:0];
        quot_next = {quot_reg[mwd_pkg::WORD_W-2:0], ge};
    end

    // The partial remainder is cleared at the start of each run.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
        end
        else if (ctrl.clear_rem)
        begin
            rem_reg <= '0;
        end
        else if (ctrl.step)
        begin
            rem_reg <= rem_next;
        end
    end

    // Dividend and quotient shift registers for the word in flight.
    always_ff @(posedge clk)
    begin
        if (ctrl.load_word)
        begin
            dvd_sh_reg <= load_data;
        end
        else if (ctrl.step)
        begin
            dvd_sh_reg <= {dvd_sh_reg[mwd_pkg::WORD_W-2:0], 1'b0};
            quot_reg   <= quot_next;
        end
    end

endmodule

[rtl/multiword_by_word_divider.sv]
// Dividend words are taken one per cycle while busy is low; the last word starts the run.
// A run takes, for each word, a fetch, a latch and 64 shift-subtract steps,
// one quotient bit per cycle in the shared subtractor; then the WORDS quotient words
// come out on consecutive cycles; with a zero divisor the sequencer goes straight to that read-out.
// rst_n clears the sequencer and counters asynchronously; the result strobe cannot be stalled.
module multiword_by_word_divider #(
    parameter int WORDS = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [mwd_pkg::WORD_W-1:0] dividend_word,
    input  logic                       dividend_negative,
    input  logic [mwd_pkg::WORD_W-1:0] divisor,
    input  logic                       last_word,
    output logic                       done,
    output logic [mwd_pkg::WORD_W-1:0] quotient_word,
    output logic                       quotient_negative,
    output logic                       divide_by_zero,
    output logic                       last_result
);

    localparam int IW = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CW = $clog2(WORDS + 1);
    localparam logic [IW-1:0] IDX_TOP = IW'(WORDS - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(WORDS);

    mwd_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   load_cnt_reg, load_cnt_next;
    logic [CW-1:0]   loaded_reg, loaded_next;
    logic [IW-1:0]   word_idx_reg, word_idx_next;
    logic [IW-1:0]   out_idx_reg, out_idx_next;
    logic [mwd_pkg::BIT_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic            sign_reg, sign_next;
    logic            dbz_reg, dbz_next;
    logic            nonzero_reg, nonzero_next;
    logic            emit_reg, emit_next;
    logic            emit_last_reg, emit_last_next;
    logic [mwd_pkg::WORD_W-1:0] divisor_reg, divisor_next;

    logic                       accept;
    logic                       dvd_we;
    logic [mwd_pkg::WORD_W-1:0] dvd_rdata;
    logic                       quot_we;
    logic [mwd_pkg::WORD_W-1:0] quot_rdata;
    logic [mwd_pkg::WORD_W-1:0] quot_next;
    logic [mwd_pkg::WORD_W-1:0] load_data;
    mwd_pkg::unit_ctrl_t        unit_ctrl;

    assign busy   = (state_reg != mwd_pkg::S_IDLE) || emit_reg;
    assign accept = start && !busy;

    // Words above the loaded ones read as zero.
    assign load_data = (CW'(word_idx_reg) < loaded_reg) ? dvd_rdata : '0;

    // Dividend word store.
    mwd_ram #(
        .WIDTH (mwd_pkg::WORD_W),
        .DEPTH (WORDS)
    ) u_dvd_ram (
        .clk   (clk),
        .we    (dvd_we),
        .waddr (load_cnt_reg[IW-1:0]),
        .wdata (dividend_word),
        .raddr (word_idx_reg),
        .rdata (dvd_rdata)
    );

    // Quotient word store.
    mwd_ram #(
        .WIDTH (mwd_pkg::WORD_W),
        .DEPTH (WORDS)
    ) u_quot_ram (
        .clk   (clk),
        .we    (quot_we),
        .waddr (word_idx_reg),
        .wdata (quot_next),
        .raddr (out_idx_reg),
        .rdata (quot_rdata)
    );

    // Shift-subtract unit.
    mwd_bit_unit u_unit (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (unit_ctrl),
        .load_data (load_data),
        .divisor   (divisor_reg),
        .quot_next (quot_next)
    );

    // Sequencer: load words, divide word by word from the top, then read out.
    always_comb
    begin
        state_next     = state_reg;
        load_cnt_next  = load_cnt_reg;
        loaded_next    = loaded_reg;
        word_idx_next  = word_idx_reg;
        out_idx_next   = out_idx_reg;
        bit_cnt_next   = bit_cnt_reg;
        sign_next      = sign_reg;
        dbz_next       = dbz_reg;
        nonzero_next   = nonzero_reg;
        divisor_next   = divisor_reg;
        emit_next      = 1'b0;
        emit_last_next = emit_last_reg;
        dvd_we         = 1'b0;
        quot_we        = 1'b0;
        unit_ctrl      = '0;

        case (state_reg)
            mwd_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (load_cnt_reg < CNT_FULL)
                    begin
                        dvd_we        = 1'b1;
                        load_cnt_next = load_cnt_reg + CW'(1);
                    end
                    if (last_word)
                    begin
                        loaded_next   = (load_cnt_reg < CNT_FULL) ?
                                        load_cnt_reg + CW'(1) : load_cnt_reg;
                        load_cnt_next = '0;
                        sign_next     = dividend_negative;
                        divisor_next  = divisor;
                        dbz_next      = (divisor == '0);
                        nonzero_next  = 1'b0;
                        word_idx_next = IDX_TOP;
                        out_idx_next  = '0;
                        unit_ctrl.clear_rem = 1'b1;
                        state_next    = (divisor == '0) ? mwd_pkg::S_READ : mwd_pkg::S_FETCH;
                    end
                end
            end
            mwd_pkg::S_FETCH:
            begin
                state_next = mwd_pkg::S_LATCH;
            end
            mwd_pkg::S_LATCH:
            begin
                unit_ctrl.load_word = 1'b1;
                bit_cnt_next        = '0;
                state_next          = mwd_pkg::S_SHIFT;
            end
            mwd_pkg::S_SHIFT:
            begin
                unit_ctrl.step = 1'b1;
                bit_cnt_next   = bit_cnt_reg + mwd_pkg::BIT_CNT_W'(1);
                if (bit_cnt_reg == mwd_pkg::BIT_LAST)
                begin
                    quot_we      = 1'b1;
                    nonzero_next = nonzero_reg || (quot_next != '0);
                    if (word_idx_reg == '0)
                    begin
                        out_idx_next = '0;
                        state_next   = mwd_pkg::S_READ;
                    end
                    else
                    begin
                        word_idx_next = word_idx_reg - IW'(1);
                        state_next    = mwd_pkg::S_FETCH;
                    end
                end
            end
            mwd_pkg::S_READ:
            begin
                emit_next      = 1'b1;
                emit_last_next = (out_idx_reg == IDX_TOP);
                if (out_idx_reg == IDX_TOP)
                begin
                    state_next = mwd_pkg::S_IDLE;
                end
                else
                begin
                    out_idx_next = out_idx_reg + IW'(1);
                end
            end
            default:
            begin
                state_next = mwd_pkg::S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mwd_pkg::S_IDLE;
            load_cnt_reg  <= '0;
            loaded_reg    <= '0;
            word_idx_reg  <= '0;
            out_idx_reg   <= '0;
            bit_cnt_reg   <= '0;
            sign_reg      <= 1'b0;
            dbz_reg       <= 1'b0;
            nonzero_reg   <= 1'b0;
            divisor_reg   <= '0;
            emit_reg      <= 1'b0;
            emit_last_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            load_cnt_reg  <= load_cnt_next;
            loaded_reg    <= loaded_next;
            word_idx_reg  <= word_idx_next;
            out_idx_reg   <= out_idx_next;
            bit_cnt_reg   <= bit_cnt_next;
            sign_reg      <= sign_next;
            dbz_reg       <= dbz_next;
            nonzero_reg   <= nonzero_next;
            divisor_reg   <= divisor_next;
            emit_reg      <= emit_next;
            emit_last_reg <= emit_last_next;
        end
    end

    // Result word outputs, straight from the registered quotient read.
    assign done              = emit_reg;
    assign quotient_word     = dbz_reg ? '0 : quot_rdata;
    assign quotient_negative = sign_reg && nonzero_reg;
    assign divide_by_zero    = dbz_reg;
    assign last_result       = emit_last_reg;

endmodule
